FILE: src/sset_pkg.sv
`default_nettype none
package sset_pkg;
	localparam int KEY_W = 32;
	localparam int DEPTH_DEF = 16;

	// input mode codes
	localparam logic [1:0] MODE_INS = 2'd0;
	localparam logic [1:0] MODE_DEL = 2'd1;
	localparam logic [1:0] MODE_RD  = 2'd2;

	// result status codes
	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_DUPLICATE = 3'd1;
	localparam logic [2:0] ST_DELETED   = 3'd2;
	localparam logic [2:0] ST_NOTFOUND  = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;
	localparam logic [2:0] ST_EMPTY     = 3'd5;
	localparam logic [2:0] ST_ELEMENT   = 3'd6;

	// cell operation codes
	localparam logic [1:0] OP_HOLD = 2'd0;
	localparam logic [1:0] OP_INS  = 2'd1;
	localparam logic [1:0] OP_DEL  = 2'd2;
	localparam logic [1:0] OP_ROT  = 2'd3;

	typedef struct packed {
		logic lt;	// occupied and below the search key
		logic eq;	// occupied and equal to the search key
	} cell_flags_t;
endpackage
`default_nettype wire

FILE: src/sset_cell.sv
`default_nettype none
module sset_cell #(
	parameter int IDX = 0,
	parameter int CW = 5
) (
	input  wire                                    clk,
	input  wire  [1:0]                             op,
	input  wire  signed [sset_pkg::KEY_W-1:0]      k,
	input  wire  [CW-1:0]                          count,
	input  wire  signed [sset_pkg::KEY_W-1:0]      left_key,
	input  wire                                    left_lt,
	input  wire  signed [sset_pkg::KEY_W-1:0]      right_key,
	input  wire  signed [sset_pkg::KEY_W-1:0]      head_key,
	output sset_pkg::cell_flags_t                  flags,
	output logic signed [sset_pkg::KEY_W-1:0]      key_q
);
	localparam logic [CW-1:0] IDX_C  = CW'(IDX);
	localparam logic [CW-1:0] NEXT_C = CW'(IDX + 1);

	logic occ;

	always_comb begin
		occ      = IDX_C < count;
		flags.lt = occ && (key_q < k);
		flags.eq = occ && (key_q == k);
	end

	// insert: cells at or past the slot shift right, slot takes the key
	// delete: cells at or past the match shift left
	// rotate: occupied region turns left by one, tail takes the head
	always_ff @(posedge clk) begin
		case (op)
			sset_pkg::OP_INS: begin
				if (!flags.lt) key_q <= left_lt ? k : left_key;
			end
			sset_pkg::OP_DEL: begin
				if (!flags.lt) key_q <= right_key;
			end
			sset_pkg::OP_ROT: begin
				key_q <= (NEXT_C < count) ? right_key : head_key;
			end
			default: begin
				key_q <= key_q;
			end
		endcase
	end
endmodule
`default_nettype wire

FILE: src/sorted_set_insert_delete_top.sv
// Sorted set: a row of DEPTH key cells kept in ascending order.
// Insert, delete and status results: one item per cycle while in_stall is low, result registered for the next cycle.
// Readout of N keys: input stalls while the row rotates one key per cycle, while out_stall is low,
// out of cell 0; the readout is paced by that single output port.
// Reset (arst_n, async, active low) clears the key count and the output/readout control;
// cell contents are not cleared and are only read below the count.
`default_nettype none
module sorted_set_insert_delete_top #(
	parameter int DEPTH = sset_pkg::DEPTH_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_stall,
	input  wire  [1:0]                          mode,
	input  wire  signed [sset_pkg::KEY_W-1:0]   key,
	output logic                                out_valid,
	input  wire                                 out_stall,
	output logic [2:0]                          status,
	output logic signed [sset_pkg::KEY_W-1:0]   value,
	output logic                                last
);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [CW-1:0] ONE_C   = CW'(1);

	// control state
	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_left_q;
	logic          rd_active_q;
	logic          out_valid_q;

	// output register
	logic [2:0]                        status_q;
	logic signed [sset_pkg::KEY_W-1:0] value_q;
	logic                              last_q;

	// cell row
	logic [1:0]                        cell_op;
	sset_pkg::cell_flags_t             flg [DEPTH];
	logic signed [sset_pkg::KEY_W-1:0] kv  [DEPTH];

	logic eq_any;
	logic out_free;
	logic acc;
	logic rd_step;
	logic load;
	logic [2:0]                        nx_status;
	logic signed [sset_pkg::KEY_W-1:0] nx_value;
	logic                              nx_last;
	logic [CW-1:0]                     nx_count;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = rd_active_q || !out_free;
	assign acc       = in_valid && !in_stall;
	assign rd_step   = rd_active_q && out_free;
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign value     = value_q;
	assign last      = last_q;

	// keys are unique, so any match in the occupied region is the match
	always_comb begin
		eq_any = 1'b0;
		for (int i = 0; i < DEPTH; i++) eq_any = eq_any | flg[i].eq;
	end

	// decode one item or one readout step into a cell operation and a result
	always_comb begin
		cell_op   = sset_pkg::OP_HOLD;
		load      = 1'b0;
		nx_status = sset_pkg::ST_EMPTY;
		nx_value  = '0;
		nx_last   = 1'b1;
		nx_count  = count_q;
		if (rd_step) begin
			cell_op   = sset_pkg::OP_ROT;
			load      = 1'b1;
			nx_status = sset_pkg::ST_ELEMENT;
			nx_value  = kv[0];
			nx_last   = (rd_left_q == ONE_C);
		end else if (acc) begin
			case (mode)
				sset_pkg::MODE_INS: begin
					load = 1'b1;
					if (eq_any) begin
						nx_status = sset_pkg::ST_DUPLICATE;
					end else if (count_q == DEPTH_C) begin
						nx_status = sset_pkg::ST_FULL;
					end else begin
						nx_status = sset_pkg::ST_INSERTED;
						cell_op   = sset_pkg::OP_INS;
						nx_count  = count_q + ONE_C;
					end
				end
				sset_pkg::MODE_DEL: begin
					load = 1'b1;
					if (count_q == '0) begin
						nx_status = sset_pkg::ST_EMPTY;
					end else if (eq_any) begin
						nx_status = sset_pkg::ST_DELETED;
						cell_op   = sset_pkg::OP_DEL;
						nx_count  = count_q - ONE_C;
					end else begin
						nx_status = sset_pkg::ST_NOTFOUND;
					end
				end
				sset_pkg::MODE_RD: begin
					// empty store answers at once; otherwise rd_active_q is set and the sweep runs from it
					load = (count_q == '0);
				end
				default: begin
					load = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rd_left_q   <= '0;
			rd_active_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= nx_count;
			if (load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			if (acc && mode == sset_pkg::MODE_RD && count_q != '0) begin
				rd_active_q <= 1'b1;
				rd_left_q   <= count_q;
			end else if (rd_step) begin
				rd_left_q <= rd_left_q - ONE_C;
				if (rd_left_q == ONE_C) rd_active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q <= nx_status;
			value_q  <= nx_value;
			last_q   <= nx_last;
		end
	end

	// row of cells; cell 0 sees a "below" neighbor so it can take the new key,
	// the last cell refills itself on delete
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic signed [sset_pkg::KEY_W-1:0] lk;
		logic signed [sset_pkg::KEY_W-1:0] rk;
		logic                              llt;
		if (g == 0) begin : g_first
			assign lk  = kv[0];
			assign llt = 1'b1;
		end else begin : g_mid
			assign lk  = kv[g-1];
			assign llt = flg[g-1].lt;
		end
		if (g == DEPTH - 1) begin : g_tail
			assign rk = kv[g];
		end else begin : g_body
			assign rk = kv[g+1];
		end
		sset_cell #(
			.IDX (g),
			.CW  (CW)
		) u_cell (
			.clk       (clk),
			.op        (cell_op),
			.k         (key),
			.count     (count_q),
			.left_key  (lk),
			.left_lt   (llt),
			.right_key (rk),
			.head_key  (kv[0]),
			.flags     (flg[g]),
			.key_q     (kv[g])
		);
	end

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("key count above depth");

	a_rd_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		rd_active_q |-> in_stall)
		else $error("input open during readout");

	a_full_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && mode == sset_pkg::MODE_INS && count_q == DEPTH_C) |=> $stable(count_q))
		else $error("count changed on insert into full store");

	a_rd_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_step && rd_left_q == ONE_C) |=> (!rd_active_q && out_valid_q && last_q))
		else $error("readout did not end on last key");
endmodule
`default_nettype wire
